FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// Each use states one property on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is applied
`define TVI_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is applied
`define TVI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset
`define TVI_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/tvi_pkg.sv
// ----------------------------------------------------------------------------
// tvi_pkg
// Widths and the cell operation word shared by the trapezoid volume
// integrator front end, queue and accumulator back end.
// ----------------------------------------------------------------------------
package tvi_pkg;

    localparam int SAMPLE_W = 16;               // Q8.8 sample
    localparam int COORD_W  = 16;               // Q8.8 coordinate
    localparam int CFG_W    = 11;               // column length register
    localparam int LINE_W   = SAMPLE_W + 2 * COORD_W; // one line store entry
    localparam int SUM_W    = SAMPLE_W + 2;     // sum of four corners
    localparam int DIFF_W   = COORD_W + 1;      // coordinate difference
    localparam int PROD1_W  = SUM_W + DIFF_W;   // sum * dx
    localparam int PROD2_W  = PROD1_W + DIFF_W; // sum * dx * dy
    localparam int ACC_W    = 64;               // volume accumulator
    localparam int Q_DEPTH  = 4;                // front-to-back queue depth
    localparam int Q_AW     = 2;                // queue pointer width

    // One word from the front end to the accumulator
    typedef struct packed {
        logic                     is_cell; // closes a cell, add its product
        logic                     last;    // final point, emit the volume
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
    } t_cell_op;

endpackage

FILE: design/tvi_front.sv
// ----------------------------------------------------------------------------
// tvi_front
// Accepts grid points, keeps the row counter and the previous column in a
// line store, forms the corner sum and the dx/dy of each closed cell.
// ----------------------------------------------------------------------------
module tvi_front
    import tvi_pkg::*;
#(
    parameter int MAX_COLUMN_LENGTH = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_wdata,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [LINE_W-1:0]       i_s_tdata,   // sample_value, x_coord, y_coord
    input  logic                    i_s_tuser,   // sample_valid
    input  logic                    i_s_tlast,   // last_point
    output logic                    o_push,
    output t_cell_op                o_op,
    input  logic                    i_q_full
);

    localparam int RW = (MAX_COLUMN_LENGTH > 2) ? $clog2(MAX_COLUMN_LENGTH) : 1;
    localparam int CW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;
    localparam logic [CW-1:0] LEN_MIN = CW'(2);
    localparam logic [CW-1:0] LEN_MAX = CW'(MAX_COLUMN_LENGTH);

    // configuration and row tracking
    logic [CFG_W-1:0]   r_col_len;
    logic [RW-1:0]      r_row;
    logic               r_first;

    // point waiting for its line store read
    logic                       r_p_valid;
    logic signed [SAMPLE_W-1:0] r_p_s;
    logic signed [COORD_W-1:0]  r_p_x;
    logic signed [COORD_W-1:0]  r_p_y;
    logic                       r_p_last;
    logic [RW-1:0]              r_p_row;
    logic                       r_p_first;

    // line store and its registered read port
    logic [LINE_W-1:0]  r_line [MAX_COLUMN_LENGTH];
    logic [LINE_W-1:0]  r_rd;

    // corners carried from the row above
    logic signed [SAMPLE_W-1:0] r_c0;
    logic signed [COORD_W-1:0]  r_c1;
    logic signed [SAMPLE_W-1:0] r_c2;
    logic signed [DIFF_W-1:0]   r_c3;

    logic               w_accept;
    logic               w_commit;
    logic [CW-1:0]      w_len_ext;
    logic [CW-1:0]      w_len_eff;
    logic [CW-1:0]      w_row_inc;
    logic               w_wrap;
    logic signed [SAMPLE_W-1:0] w_ps;
    logic signed [COORD_W-1:0]  w_px;
    logic signed [COORD_W-1:0]  w_py;
    logic signed [SUM_W-1:0]    w_sum;
    logic signed [DIFF_W-1:0]   w_dy;
    logic signed [DIFF_W-1:0]   w_dx_next;
    logic               w_cell;

    // handshake: one point in flight, released when the queue has room
    assign o_s_tready = !r_p_valid || !i_q_full;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_commit   = r_p_valid && !i_q_full;

    // clamped column length and row wrap
    always_comb begin
        w_len_ext = CW'(r_col_len);
        if (w_len_ext < LEN_MIN) begin
            w_len_eff = LEN_MIN;
        end else if (w_len_ext > LEN_MAX) begin
            w_len_eff = LEN_MAX;
        end else begin
            w_len_eff = w_len_ext;
        end
        w_row_inc = CW'(r_row) + CW'(1);
        w_wrap    = (w_row_inc >= w_len_eff);
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_len <= CFG_W'(2);
        end else if (i_cfg_we) begin
            r_col_len <= i_cfg_wdata;
        end
    end

    // row counter and first-column flag, advanced per accepted point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_first <= 1'b1;
        end else if (w_accept) begin
            if (i_s_tlast) begin
                r_row   <= '0;
                r_first <= 1'b1;
            end else if (w_wrap) begin
                r_row   <= '0;
                r_first <= 1'b0;
            end else begin
                r_row   <= w_row_inc[RW-1:0];
            end
        end
    end

    // pending point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (w_accept) begin
            r_p_valid <= 1'b1;
        end else if (w_commit) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p_s     <= i_s_tuser ? i_s_tdata[SAMPLE_W-1:0] : '0;
            r_p_x     <= i_s_tdata[SAMPLE_W +: COORD_W];
            r_p_y     <= i_s_tdata[SAMPLE_W + COORD_W +: COORD_W];
            r_p_last  <= i_s_tlast;
            r_p_row   <= r_row;
            r_p_first <= r_first;
        end
    end

    // line store: read at accept, write the point back at commit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_line[r_row];
        end
        if (w_commit) begin
            r_line[r_p_row] <= {r_p_y, r_p_x, r_p_s};
        end
    end

    // cell terms
    always_comb begin
        w_ps      = r_rd[SAMPLE_W-1:0];
        w_px      = r_rd[SAMPLE_W +: COORD_W];
        w_py      = r_rd[SAMPLE_W + COORD_W +: COORD_W];
        w_sum     = SUM_W'(r_c0) + SUM_W'(w_ps) + SUM_W'(r_c2) + SUM_W'(r_p_s);
        w_dy      = DIFF_W'(w_py) - DIFF_W'(r_c1);
        w_dx_next = DIFF_W'(r_p_x) - DIFF_W'(w_px);
        w_cell    = !r_p_first && (r_p_row != '0);
    end

    // corner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else if (w_commit) begin
            if (!r_p_first) begin
                r_c0 <= w_ps;
                r_c1 <= w_py;
                r_c3 <= w_dx_next;
            end
            r_c2 <= r_p_s;
        end
    end

    // queue word: only cells and last points need the back end
    assign o_push       = w_commit && (w_cell || r_p_last);
    assign o_op.is_cell = w_cell;
    assign o_op.last    = r_p_last;
    assign o_op.sum     = w_sum;
    assign o_op.dx      = r_c3;
    assign o_op.dy      = w_dy;

endmodule

FILE: design/tvi_queue.sv
// ----------------------------------------------------------------------------
// tvi_queue
// Short FIFO of cell words between the front end and the accumulator.
// ----------------------------------------------------------------------------
module tvi_queue
    import tvi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_cell_op    i_op,
    output logic        o_full,
    input  logic        i_pop,
    output t_cell_op    o_op,
    output logic        o_empty
);

    t_cell_op           r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wp;
    logic [Q_AW-1:0]    r_rp;
    logic [Q_AW:0]      r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

FILE: design/tvi_back.sv
// ----------------------------------------------------------------------------
// tvi_back
// Two-stage multiply of the corner sum by dx and dy, saturating 64-bit
// accumulate, and the output register for the volume word.
// ----------------------------------------------------------------------------
module tvi_back
    import tvi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_op            i_op,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [ACC_W-1:0]    o_m_tdata,   // volume
    output logic                o_m_tuser    // overflowed
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                       w_en;

    // stage A: sum * dx
    logic                       r_a_valid;
    logic                       r_a_cell;
    logic                       r_a_last;
    logic signed [DIFF_W-1:0]   r_a_dy;
    logic signed [PROD1_W-1:0]  r_a_prod;

    // stage B: (sum * dx) * dy
    logic                       r_b_valid;
    logic                       r_b_cell;
    logic                       r_b_last;
    logic signed [PROD2_W-1:0]  r_b_prod;

    // accumulator and result
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_sat;
    logic                       r_out_valid;
    logic [ACC_W-1:0]           r_out_vol;
    logic                       r_out_ovf;

    logic signed [SUM_W-1:0]    w_sum;
    logic signed [DIFF_W-1:0]   w_dx;
    logic signed [ACC_W-1:0]    w_add;
    logic signed [ACC_W:0]      w_wide;
    logic                       w_ovf;
    logic signed [ACC_W-1:0]    w_acc_next;

    // whole back end advances unless a result is stuck at the output
    assign w_en  = !r_out_valid || i_m_tready;
    assign o_pop = w_en && !i_empty;
    assign w_sum = i_op.sum;
    assign w_dx  = i_op.dx;

    // stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_cell <= i_op.is_cell;
            r_a_last <= i_op.last;
            r_a_dy   <= i_op.dy;
            r_a_prod <= PROD1_W'(w_sum) * PROD1_W'(w_dx);
        end
    end

    // stage B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_a_valid) begin
            r_b_cell <= r_a_cell;
            r_b_last <= r_a_last;
            r_b_prod <= PROD2_W'(r_a_prod) * PROD2_W'(r_a_dy);
        end
    end

    // saturating add
    always_comb begin
        w_add  = r_b_cell ? ACC_W'(r_b_prod) : '0;
        w_wide = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_add);
        w_ovf  = (w_wide[ACC_W] != w_wide[ACC_W-1]);
        if (w_ovf) begin
            w_acc_next = w_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc_next = w_wide[ACC_W-1:0];
        end
    end

    // accumulator, cleared after the last point of a grid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_sat <= 1'b0;
        end else if (w_en && r_b_valid) begin
            if (r_b_last) begin
                r_acc <= '0;
                r_sat <= 1'b0;
            end else begin
                r_acc <= w_acc_next;
                r_sat <= r_sat || w_ovf;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_b_valid && r_b_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_b_valid && r_b_last) begin
            r_out_vol <= w_acc_next;
            r_out_ovf <= r_sat || w_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_vol;
    assign o_m_tuser  = r_out_ovf;

endmodule

FILE: design/trapezoid_volume_integrator.sv
// The last point passes the pending register, queue, stages A and B and output register.
// Throughput: one grid point per cycle while the queue has room; the line store has
// one read and one write per cycle and the multiply-accumulate is pipelined (two
// multiply stages, one add). A stalled result is held in the output register; the
// 4-entry queue keeps input flowing. Reset is synchronous, active low; it clears control,
// corners and accumulator at once. The line store is not cleared; stale reads go unused.
// ----------------------------------------------------------------------------
// trapezoid_volume_integrator
// Two-dimensional trapezoidal rule over a grid streamed column by column;
// gives the volume with 26 fractional bits on the last point.
// ----------------------------------------------------------------------------
module trapezoid_volume_integrator
    import tvi_pkg::*;
#(
    parameter int MAX_COLUMN_LENGTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,  // column_length
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [LINE_W-1:0]   i_s_tdata,    // [15:0] sample_value, [31:16] x_coord,
                                              // [47:32] y_coord
    input  logic                i_s_tuser,    // sample_valid
    input  logic                i_s_tlast,    // last_point
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [ACC_W-1:0]    o_m_tdata,    // [63:0] volume
    output logic                o_m_tuser     // overflowed
);

    logic       w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_cell_op   w_op_in;
    t_cell_op   w_op_out;

    // point intake and line store
    tvi_front #(
        .MAX_COLUMN_LENGTH (MAX_COLUMN_LENGTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_push      (w_push),
        .o_op        (w_op_in),
        .i_q_full    (w_full)
    );

    // cell word queue
    tvi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_op_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_op    (w_op_out),
        .o_empty (w_empty)
    );

    // multiply-accumulate and result
    tvi_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_op_out),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

FILE: design/tvi_checker.sv
// ----------------------------------------------------------------------------
// tvi_checker
// Port-level checks on the trapezoid volume integrator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tvi_checker
    import tvi_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    input  logic                i_s_tvalid,
    input  logic                o_s_tready,
    input  logic [LINE_W-1:0]   i_s_tdata,
    input  logic                i_s_tuser,
    input  logic                i_s_tlast,
    input  logic                o_m_tvalid,
    input  logic                i_m_tready,
    input  logic [ACC_W-1:0]    o_m_tdata,
    input  logic                o_m_tuser
);

    // a stalled result word holds
    `TVI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result word changed while stalled")

    // reset drops any pending result
    `TVI_ASSERT_NEXT_ALWAYS(a_rst_out, i_clk, !i_rst_n, !o_m_tvalid, "result valid right after reset")

    // reset empties the front end and the queue, so input is taken at once
    `TVI_ASSERT_NEXT_ALWAYS(a_rst_ready, i_clk, !i_rst_n, o_s_tready, "input not ready right after reset")

    // with the output draining, a stalled input must leave ready low only briefly
    `TVI_ASSERT(a_ready_drain, i_clk, i_rst_n, !o_m_tvalid && $past(!o_m_tvalid) && $past(!o_m_tvalid, 2) && $past(!o_m_tvalid, 3) && $past(!o_m_tvalid, 4) && $past(i_rst_n, 5), o_s_tready || $past(o_s_tready), "input stalled while the back end is free")

endmodule

bind trapezoid_volume_integrator tvi_checker u_tvi_checker (.*);
